>>> rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies.
`default_nettype none
package mhpq_pkg;

  localparam int unsigned KeyWidth    = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;

  typedef logic signed [KeyWidth-1:0] key_t;
  typedef logic [StatusWidth-1:0]     status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_POPPED    = 2'd1;
  localparam status_t ST_POP_EMPTY = 2'd2;
  localparam status_t ST_FULL_DROP = 2'd3;

endpackage
`default_nettype wire

>>> rtl/max_heap_priority_queue.sv
// Max-heap priority queue: control sequencer and the heap memory.
// Depends on mhpq_pkg.
//
// Usage: each input word (op, value) either inserts a signed key or pops the
// largest key held. Every input word gives exactly one output word:
// top_value (popped key, else zero), status and count (entries after the op).
// Popping an empty heap or inserting into a full one is flagged and leaves
// the heap unchanged.
// Both channels are valid/ready. An input word is taken only while the
// sequencer is idle; one word is in work at a time.
// Structure: the heap lives in a memory with two registered read ports and one
// write port. In each sift level the read is issued, compared and written back
// while the next read goes out. An insert reads the parent and climbs level by
// level (an insert into an empty heap is written at once); a pop reads the root
// and the last entry, then descends level by level; a dropped insert or an
// empty pop goes straight to the result.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds in its final state and takes no new word, but a new word
// is taken as soon as the result is loaded, even if not yet consumed.
// Reset clears the entry count, the state and out_valid; the memory is not cleared.
`default_nettype none
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               op,
  input  wire logic signed [mhpq_pkg::KeyWidth-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mhpq_pkg::KeyWidth-1:0]    top_value,
  output logic [mhpq_pkg::StatusWidth-1:0]        status,
  output logic [mhpq_pkg::CountWidth-1:0]         count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(2 * CAPACITY + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_UPW  = 3'd2;
  localparam logic [2:0] S_POPR = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  mhpq_pkg::key_t mem [CAPACITY];
  mhpq_pkg::key_t rd0, rd1;

  logic [2:0]        state, state_next;
  logic [PW-1:0]     pos, pos_next;
  logic [CW-1:0]     entries, entries_next;
  mhpq_pkg::key_t    key, key_next;
  mhpq_pkg::key_t    res_top, res_top_next;
  mhpq_pkg::status_t res_status, res_status_next;

  logic              we;
  logic [AW-1:0]     wa, ra0, ra1;
  mhpq_pkg::key_t    wd;

  logic [PW-1:0]     parent, left, right, sel, n_pos, ins_pos;
  mhpq_pkg::key_t    best;
  logic              load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    parent  = pos >> 1;
    left    = pos << 1;
    right   = left + PW'(1);
    n_pos   = PW'(entries);
    ins_pos = PW'(entries) + PW'(1);
    sel     = pos;
    best    = key;
    if ((left <= n_pos) && (key < rd0)) begin
      sel  = left;
      best = rd0;
    end
    if ((right <= n_pos) && (best < rd1)) begin
      sel  = right;
      best = rd1;
    end
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    entries_next    = entries;
    key_next        = key;
    res_top_next    = res_top;
    res_status_next = res_status;
    we  = 1'b0;
    wa  = AW'(pos - PW'(1));
    wd  = key;
    ra0 = '0;
    ra1 = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_top_next = '0;
          if (op == mhpq_pkg::OP_INSERT) begin
            if (entries == CW'(CAPACITY)) begin
              res_status_next = mhpq_pkg::ST_FULL_DROP;
              state_next      = S_DONE;
            end else begin
              res_status_next = mhpq_pkg::ST_INSERTED;
              key_next        = value;
              pos_next        = ins_pos;
              entries_next    = entries + CW'(1);
              if (entries == '0) begin
                we         = 1'b1;
                wa         = '0;
                wd         = value;
                state_next = S_DONE;
              end else begin
                ra0        = AW'((ins_pos >> 1) - PW'(1));
                state_next = S_UP;
              end
            end
          end else begin
            if (entries == '0) begin
              res_status_next = mhpq_pkg::ST_POP_EMPTY;
              state_next      = S_DONE;
            end else begin
              res_status_next = mhpq_pkg::ST_POPPED;
              ra0             = '0;
              ra1             = AW'(entries - CW'(1));
              entries_next    = entries - CW'(1);
              state_next      = S_POPR;
            end
          end
        end
      end
      S_UP: begin
        we = 1'b1;
        if (rd0 < key) begin
          wd       = rd0;
          pos_next = parent;
          if (parent > PW'(1)) begin
            ra0 = AW'((parent >> 1) - PW'(1));
          end else begin
            state_next = S_UPW;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_UPW: begin
        we         = 1'b1;
        wa         = '0;
        state_next = S_DONE;
      end
      S_POPR: begin
        res_top_next = rd0;
        key_next     = rd1;
        pos_next     = PW'(1);
        ra0          = AW'(1);
        ra1          = AW'(2);
        state_next   = S_DOWN;
      end
      S_DOWN: begin
        we = 1'b1;
        if (sel == pos) begin
          state_next = S_DONE;
        end else begin
          wd       = best;
          pos_next = sel;
          ra0      = AW'((sel << 1) - PW'(1));
          ra1      = AW'(sel << 1);
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      entries   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      entries <= entries_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    key        <= key_next;
    res_top    <= res_top_next;
    res_status <= res_status_next;
    if (load_out) begin
      top_value <= res_top;
      status    <= res_status;
      count     <= mhpq_pkg::CountWidth'(entries);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE || (state == S_IDLE && !in_valid)) |-> !we)
    else $error("memory write outside a sift");

  a_empty_pop_count: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status == mhpq_pkg::ST_POP_EMPTY) |-> (entries == '0))
    else $error("pop on empty with entries held");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status == mhpq_pkg::ST_FULL_DROP) |-> (entries == CW'(CAPACITY)))
    else $error("insert dropped while not full");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && op == mhpq_pkg::OP_POP && entries != '0)
      |=> (entries == $past(entries) - CW'(1)))
    else $error("pop did not shrink the heap");

endmodule
`default_nettype wire

>>> dv/mhpq_checker.sv
// Checker for the max-heap priority queue: watches both channels, keeps its own heap.
// Every output word is compared with the oldest predicted word.
// Depends on mhpq_pkg.
module mhpq_checker #(
  parameter int Cap = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    op,
  input  mhpq_pkg::key_t          value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  mhpq_pkg::key_t          top_value,
  input  mhpq_pkg::status_t       status,
  input  logic [mhpq_pkg::CountWidth-1:0] count,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    mhpq_pkg::key_t                  top;
    mhpq_pkg::status_t               st;
    logic [mhpq_pkg::CountWidth-1:0] cnt;
  } heap_result_t;

  mhpq_pkg::key_t keys [1:Cap];
  int             held;
  heap_result_t   expected_words [$];
  int             fails;

  initial begin
    fail_count = 0;
    pending = 0;
    fails = 0;
    held = 0;
  end

  function automatic void swap_keys(int a, int b);
    mhpq_pkg::key_t t;
    t = keys[a];
    keys[a] = keys[b];
    keys[b] = t;
  endfunction

  function automatic heap_result_t apply_word(logic o, mhpq_pkg::key_t v);
    heap_result_t r;
    int pos;
    int par;
    int lc;
    int rc;
    int big;
    r.top = '0;
    if (o == mhpq_pkg::OP_INSERT) begin
      if (held >= Cap) begin
        r.st = mhpq_pkg::ST_FULL_DROP;
      end else begin
        held++;
        keys[held] = v;
        pos = held;
        while (pos > 1) begin
          par = pos / 2;
          if (!(keys[par] < keys[pos])) break;
          swap_keys(par, pos);
          pos = par;
        end
        r.st = mhpq_pkg::ST_INSERTED;
      end
    end else begin
      if (held == 0) begin
        r.st = mhpq_pkg::ST_POP_EMPTY;
      end else begin
        r.top = keys[1];
        keys[1] = keys[held];
        held--;
        pos = 1;
        forever begin
          lc = 2 * pos;
          rc = lc + 1;
          big = pos;
          if (lc <= held && keys[big] < keys[lc]) big = lc;
          if (rc <= held && keys[big] < keys[rc]) big = rc;
          if (big == pos) break;
          swap_keys(pos, big);
          pos = big;
        end
        r.st = mhpq_pkg::ST_POPPED;
      end
    end
    r.cnt = held[mhpq_pkg::CountWidth-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      held = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected: top_value %0d status %0d count %0d",
                 top_value, status, count);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (top_value !== want.top) begin
            $error("top_value expected %0d actual %0d", want.top, top_value);
            fails++;
          end
          if (status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, status);
            fails++;
          end
          if (count !== want.cnt) begin
            $error("count expected %0d actual %0d", want.cnt, count);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) expected_words.push_back(apply_word(op, value));
    end
    pending <= expected_words.size();
    fail_count <= fails;
  end

endmodule

>>> dv/testbench.sv
// Top of the max-heap priority queue bench: clock, reset, stimulus and verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and mhpq_checker.
module testbench;

  localparam int Cap = 64;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            op = mhpq_pkg::OP_INSERT;
  mhpq_pkg::key_t                  value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  mhpq_pkg::key_t                  top_value;
  mhpq_pkg::status_t               status;
  logic [mhpq_pkg::CountWidth-1:0] count;

  int   fail_count;
  int   pending;
  int   tx_idle = 0;
  int   rx_idle = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_cnt = 0;
  int   track_cnt = 0;
  logic filling = 1'b1;
  int   edge_hits = 0;

  max_heap_priority_queue #(.CAPACITY(Cap)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .top_value(top_value), .status(status), .count(count)
  );

  mhpq_checker #(.Cap(Cap)) heap_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .top_value(top_value), .status(status), .count(count),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_word(input logic o, input mhpq_pkg::key_t v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == mhpq_pkg::OP_INSERT) begin
      if (track_cnt < Cap) track_cnt++;
    end else if (track_cnt > 0) begin
      track_cnt--;
    end
  endtask

  function automatic mhpq_pkg::key_t pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3: return mhpq_pkg::key_t'($urandom);
      4, 5, 6:    return mhpq_pkg::key_t'(int'($urandom_range(16)) - 8);
      7:          return 32'sh7FFF_FFFF;
      8:          return 32'sh8000_0000;
      default:    return mhpq_pkg::key_t'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // fill toward full, try a few drops, then drain to empty and pop it a few times; repeat
  task automatic run_random(input int n);
    logic o;
    repeat (n) begin
      if ($urandom_range(99) < 10) begin
        o = logic'($urandom_range(1));
      end else if (filling) begin
        o = ($urandom_range(99) < 85) ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_POP;
        if (track_cnt == Cap) begin
          o = mhpq_pkg::OP_INSERT;
          edge_hits++;
        end
      end else begin
        o = ($urandom_range(99) < 85) ? mhpq_pkg::OP_POP : mhpq_pkg::OP_INSERT;
        if (track_cnt == 0) begin
          o = mhpq_pkg::OP_POP;
          edge_hits++;
        end
      end
      send_word(o, pick_key());
      if (edge_hits >= 3) begin
        edge_hits = 0;
        filling = !filling;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_idle = 30;
    rx_idle = 56;
    send_word(mhpq_pkg::OP_POP, mhpq_pkg::key_t'($urandom));
    send_word(mhpq_pkg::OP_POP, mhpq_pkg::key_t'($urandom));
    send_word(mhpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_word(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
    send_word(mhpq_pkg::OP_INSERT, 32'sd0);
    send_word(mhpq_pkg::OP_INSERT, -32'sd1);
    send_word(mhpq_pkg::OP_INSERT, 32'sd1);
    send_word(mhpq_pkg::OP_INSERT, 32'sd5);
    send_word(mhpq_pkg::OP_INSERT, 32'sd5);
    send_word(mhpq_pkg::OP_INSERT, 32'sd5);
    repeat (8) send_word(mhpq_pkg::OP_POP, mhpq_pkg::key_t'($urandom));
    send_word(mhpq_pkg::OP_POP, 32'sh7FFF_FFFF);
    // equal children on sift-down
    send_word(mhpq_pkg::OP_INSERT, 32'sd9);
    send_word(mhpq_pkg::OP_INSERT, 32'sd3);
    send_word(mhpq_pkg::OP_INSERT, 32'sd3);
    send_word(mhpq_pkg::OP_INSERT, 32'sd1);
    repeat (4) send_word(mhpq_pkg::OP_POP, mhpq_pkg::key_t'($urandom));

    run_random(150);
    tx_idle = 56;
    rx_idle = 30;
    run_random(150);
    tx_idle = 0;
    rx_idle = 0;
    hold_req <= 1'b1;
    run_random(150);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mhpq_pkg.sv
rtl/max_heap_priority_queue.sv
dv/mhpq_checker.sv
dv/testbench.sv
